>>> src/tlvs_pkg.sv
package tlvs_pkg;

  localparam int MAX_BYTES = 1024;
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  // record end can reach the buffer end plus the largest span
  localparam int END_W     = $clog2(MAX_BYTES + 258);
  localparam int SPAN_W    = 9;
  localparam int NXT_W     = 9;

  localparam logic [NXT_W-1:0] TAG_NONE = 9'h100;

  typedef struct packed {
    logic load;        // accepted load request
    logic sort_go;     // accepted last load, start the sort
    logic rd_len;      // read the length byte of the current record
    logic eval;        // length byte is in, act on the record
    logic copy;        // move one record byte to the sorted store
    logic next_pass;   // advance to the next tag
    logic finish_ok;   // sort done, buffer good
    logic finish_bad;  // sort done, buffer corrupt
    logic fetch;       // accepted fetch request that finds a byte
  } tlvs_cmd_t;

  typedef struct packed {
    logic pos_end;     // scan reached the buffer end
    logic lone_tag;    // tag byte with no length byte behind it
    logic over;        // record runs past the buffer end
    logic match;       // record tag equals the tag of this pass
    logic next_none;   // no larger tag seen in this pass
    logic span_last;   // last byte of the record copy
    logic fetch_hit;   // a sorted byte is left to fetch
  } tlvs_sts_t;

endpackage

>>> src/tlvs_dp.sv
module tlvs_dp
  import tlvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tlvs_cmd_t  cmd,
  input  logic [7:0] in_data_byte,
  output tlvs_sts_t  sts,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_corrupt
);

  logic [7:0] in_mem     [MAX_BYTES];
  logic [7:0] sorted_mem [MAX_BYTES];

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  rptr_r;
  logic [CNT_W-1:0]  slen_r;
  logic              corrupt_r;
  logic              cp_pend_r;

  logic [CNT_W-1:0]  pos_r;
  logic [CNT_W-1:0]  len_r;
  logic [CNT_W-1:0]  wr_r;
  logic [7:0]        rdata_r;
  logic [7:0]        tag_r;
  logic [7:0]        cur_r;
  logic [NXT_W-1:0]  next_r;
  logic              pass0_r;
  logic [SPAN_W-1:0] span_cnt_r;
  logic [7:0]        out_raw_r;
  logic              out_last_r;
  logic              out_corrupt_r;

  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  rptr_inc;
  logic [ADDR_W-1:0] raddr;
  logic [SPAN_W-1:0] span;
  logic [END_W-1:0]  rec_end;
  logic              room;
  logic              take_min;

  assign room     = cnt_r < CNT_W'(MAX_BYTES);
  assign cnt_nxt  = room ? cnt_r + 1'b1 : cnt_r;
  assign pos_inc  = pos_r + 1'b1;
  assign rptr_inc = rptr_r + 1'b1;
  assign raddr    = cmd.rd_len ? pos_inc[ADDR_W-1:0] : pos_r[ADDR_W-1:0];
  assign span     = {1'b0, rdata_r} + SPAN_W'(2);
  assign rec_end  = END_W'(pos_r) + END_W'(span);
  assign take_min = (pass0_r || (tag_r > cur_r)) && ({1'b0, tag_r} < next_r);

  assign sts.pos_end   = pos_r >= len_r;
  assign sts.lone_tag  = pass0_r && (pos_inc >= len_r);
  assign sts.over      = pass0_r && (rec_end > END_W'(len_r));
  assign sts.match     = !pass0_r && (tag_r == cur_r);
  assign sts.next_none = next_r == TAG_NONE;
  assign sts.span_last = span_cnt_r == SPAN_W'(1);
  assign sts.fetch_hit = rptr_r < slen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rptr_r    <= '0;
      slen_r    <= '0;
      corrupt_r <= 1'b0;
      cp_pend_r <= 1'b0;
    end else begin
      cp_pend_r <= cmd.copy;
      if (cmd.sort_go) begin
        cnt_r <= '0;
      end else if (cmd.load) begin
        cnt_r <= cnt_nxt;
      end
      if (cmd.finish_ok || cmd.finish_bad) begin
        slen_r    <= len_r;
        rptr_r    <= '0;
        corrupt_r <= cmd.finish_bad;
      end else if (cmd.fetch) begin
        rptr_r <= rptr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      in_mem[cnt_r[ADDR_W-1:0]] <= in_data_byte;
    end
    rdata_r <= in_mem[raddr];
  end

  // the store write lands in the cycle after the copy read
  always_ff @(posedge clk) begin
    if (cp_pend_r) begin
      sorted_mem[wr_r[ADDR_W-1:0]] <= rdata_r;
    end
    if (cmd.fetch) begin
      out_raw_r <= sorted_mem[rptr_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_go) begin
      len_r   <= cnt_nxt;
      pos_r   <= '0;
      wr_r    <= '0;
      pass0_r <= 1'b1;
      next_r  <= TAG_NONE;
    end else if (cmd.next_pass) begin
      cur_r   <= next_r[7:0];
      next_r  <= TAG_NONE;
      pass0_r <= 1'b0;
      pos_r   <= '0;
    end else if (cmd.rd_len) begin
      tag_r <= rdata_r;
    end else if (cmd.eval) begin
      if (sts.match) begin
        span_cnt_r <= span;
      end else begin
        pos_r <= rec_end[CNT_W-1:0];
        if (take_min) begin
          next_r <= {1'b0, tag_r};
        end
      end
    end else if (cmd.copy) begin
      pos_r      <= pos_inc;
      span_cnt_r <= span_cnt_r - 1'b1;
    end
    if (cp_pend_r) begin
      wr_r <= wr_r + 1'b1;
    end
    if (cmd.fetch) begin
      out_last_r    <= rptr_inc == slen_r;
      out_corrupt_r <= corrupt_r;
    end
  end

  assign out_byte    = out_corrupt_r ? 8'd0 : out_raw_r;
  assign out_last    = out_last_r;
  assign out_corrupt = out_corrupt_r;

  a_copy_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cp_pend_r |-> (wr_r < len_r))
    else $error("sorted store write past buffer length");

  a_finish_resets_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish_ok || cmd.finish_bad) |=> (rptr_r == '0 && slen_r == $past(len_r)))
    else $error("sort finish did not rewind the fetch pointer");

  a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> (rptr_r < slen_r))
    else $error("fetch past the sorted buffer");

endmodule

>>> src/tlvs_ctrl.sv
module tlvs_ctrl
  import tlvs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_func,
  input  logic      in_last_byte,
  output logic      out_valid,
  input  logic      out_ready,
  input  tlvs_sts_t sts,
  output tlvs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAG  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_SPAN = 3'd3;
  localparam logic [2:0] S_COPY = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       idle;
  logic       fire;

  assign idle = state_r == S_IDLE;
  // loads make no result, so a stalled output only holds back fetches
  assign in_ready = idle && (!out_valid_r || out_ready || !in_func);
  assign fire     = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    cmd.load   = fire && !in_func;
    cmd.fetch  = fire && in_func && sts.fetch_hit;
    case (state_r)
      S_IDLE: begin
        if (cmd.load && in_last_byte) begin
          cmd.sort_go = 1'b1;
          state_nxt   = S_TAG;
        end
      end
      S_TAG: begin
        if (sts.pos_end) begin
          if (sts.next_none) begin
            cmd.finish_ok = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.next_pass = 1'b1;
          end
        end else if (sts.lone_tag) begin
          cmd.finish_bad = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.rd_len = 1'b1;
        state_nxt  = S_SPAN;
      end
      S_SPAN: begin
        if (sts.over) begin
          cmd.finish_bad = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.eval  = 1'b1;
          state_nxt = sts.match ? S_COPY : S_TAG;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.span_last) begin
          state_nxt = S_TAG;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fetch) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("request taken while sorting");

  a_copy_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY && sts.span_last) |=> (state_r == S_TAG))
    else $error("record copy did not return to the scan");

  a_fetch_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |=> out_valid_r)
    else $error("fetch produced no result");

endmodule

>>> src/tlv_record_sort_by_tag.sv
// Load request: no result.
// Fetch request: result valid in the cycle after acceptance; one fetch per
//   cycle unless the output stalls. Sort after the last byte: (D+1) scan
//   passes, D = number of distinct tags (single read port).
// Input not ready during the sort. Reset (rst_n low, synchronous) empties the
//   buffer and the sorted result; store contents are not cleared.
module tlv_record_sort_by_tag
  import tlvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_corrupt
);

  tlvs_cmd_t cmd;
  tlvs_sts_t sts;

  tlvs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  tlvs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_data_byte (in_data_byte),
    .sts          (sts),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_corrupt  (out_corrupt)
  );

endmodule
